@@ rtl/key_driven_pedal_steer_smoother_top_macros.svh @@
// Assertion macros shared by the smoother modules
`ifndef KEY_DRIVEN_PEDAL_STEER_SMOOTHER_TOP_MACROS_SVH
`define KEY_DRIVEN_PEDAL_STEER_SMOOTHER_TOP_MACROS_SVH

// Condition must hold in the same cycle as the trigger
`define KDPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition must hold in the cycle after the trigger
`define KDPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/kdps_pkg.sv @@
// Types, constants and helpers for the pedal and steering smoother
package kdps_pkg;

  localparam int VALUE_FRAC_BITS = 14;
  localparam int TIME_FRAC_BITS  = 16;
  localparam int GAIN_FRAC_BITS  = 8;

  localparam int CHAN_COUNT = 4;
  localparam int CH_W       = $clog2(CHAN_COUNT);
  localparam int KEY_COUNT  = 5;
  localparam int KEY_ID_W   = 3;
  localparam int OP_W       = 4;

  localparam int VAL_W   = 16;
  localparam int WIDE_W  = 26;
  localparam int TIME_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int DELTA_W = 15;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W  = 2;
  localparam int OUT_U_W = 15;
  localparam int MUL_A_W = 32;
  localparam int PROD_W  = MUL_A_W + TIME_W;
  localparam int SHIFT   = GAIN_FRAC_BITS + TIME_FRAC_BITS;
  localparam int INC_W   = PROD_W - SHIFT;

  localparam logic signed [WIDE_W-1:0] ONE_WIDE = WIDE_W'(1 << VALUE_FRAC_BITS);
  localparam logic signed [VAL_W-1:0]  ONE_V    = VAL_W'(1 << VALUE_FRAC_BITS);

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RESET    = GAIN_W'(1024);
  localparam logic [DELTA_W-1:0] DELTA_RESET   = DELTA_W'(328);
  localparam logic [TIME_W-1:0]  SUBSTEP_RESET = TIME_W'(66);

  localparam logic [MODE_W-1:0] MODE_KEYBOARD = MODE_W'(0);

  // Channel slots
  localparam logic [CH_W-1:0] CH_THR = CH_W'(0);
  localparam logic [CH_W-1:0] CH_STR = CH_W'(1);
  localparam logic [CH_W-1:0] CH_BRK = CH_W'(2);
  localparam logic [CH_W-1:0] CH_CLU = CH_W'(3);
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHAN_COUNT - 1);

  // Key flag positions
  localparam int KEY_THR   = 0;
  localparam int KEY_BRK   = 1;
  localparam int KEY_LEFT  = 2;
  localparam int KEY_RIGHT = 3;
  localparam int KEY_CLU   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_KEY            = 4'd0,
    OP_RELEASE_KEYS   = 4'd1,
    OP_THR_UP         = 4'd2,
    OP_THR_DOWN       = 4'd3,
    OP_LEFT           = 4'd4,
    OP_RIGHT          = 4'd5,
    OP_CLU_UP         = 4'd6,
    OP_CLU_DOWN       = 4'd7,
    OP_CENTER         = 4'd8,
    OP_RELEASE_PEDALS = 4'd9,
    OP_TICK           = 4'd10,
    OP_CLEAR          = 4'd11
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_MODE    = 3'd0,
    REG_KEYBOARD_MODE = 3'd1,
    REG_STEERING_GAIN = 3'd2,
    REG_THROTTLE_GAIN = 3'd3,
    REG_BRAKING_GAIN  = 3'd4,
    REG_CLUTCH_GAIN   = 3'd5,
    REG_TARGET_DELTA  = 3'd6,
    REG_SUBSTEP_TIME  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_MUL_MAG,
    ST_MUL_H,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [KEY_ID_W-1:0] key_id;
    logic                pressed;
    logic [TIME_W-1:0]   step_time;
  } cmd_item_t;

  typedef struct packed {
    logic [OUT_U_W-1:0]      throttle_out;
    logic signed [VAL_W-1:0] steering_out;
    logic [OUT_U_W-1:0]      braking_out;
    logic [OUT_U_W-1:0]      clutch_out;
  } res_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic            accept;
    logic            load_out;
    logic            start_sub;
    logic            mul_mag;
    logic            mul_h;
    logic            update;
    logic [CH_W-1:0] ch;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic tick_work;
    logic sub_done;
  } ctl_stat_t;

  // Clamp a wide value to the range of its channel
  function automatic logic signed [VAL_W-1:0] clamp_val(
    input logic signed [WIDE_W-1:0] v,
    input logic                     is_steer
  );
    logic signed [WIDE_W-1:0] lo;
    logic signed [WIDE_W-1:0] r;
    lo = is_steer ? -ONE_WIDE : '0;
    if (v < lo) begin
      r = lo;
    end else if (v > ONE_WIDE) begin
      r = ONE_WIDE;
    end else begin
      r = v;
    end
    return VAL_W'(r);
  endfunction

endpackage

@@ rtl/kdps_dp.sv @@
// Datapath: registers, key and target logic, shared lag multiplier
`include "key_driven_pedal_steer_smoother_top_macros.svh"

module kdps_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [kdps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kdps_pkg::CFG_W-1:0]        cfg_data,
  input  kdps_pkg::cmd_item_t               cmd_item,
  input  kdps_pkg::ctl_cmd_t                ctl,
  output kdps_pkg::ctl_stat_t               stat,
  output kdps_pkg::res_item_t               res_item
);
  import kdps_pkg::*;

  // Configuration
  logic [MODE_W-1:0]  input_mode;
  logic               keyboard_mode;
  logic [GAIN_W-1:0]  gain [CHAN_COUNT];
  logic [DELTA_W-1:0] target_delta;
  logic [TIME_W-1:0]  substep_time;

  // Block state
  logic [KEY_COUNT-1:0]    held;
  logic [KEY_COUNT-1:0]    held_next;
  logic signed [VAL_W-1:0] tgt [CHAN_COUNT];
  logic signed [VAL_W-1:0] tgt_next [CHAN_COUNT];
  logic signed [VAL_W-1:0] smooth [CHAN_COUNT];
  logic [TIME_W-1:0]       elapsed;
  logic [TIME_W-1:0]       step_reg;
  logic [TIME_W-1:0]       h_reg;
  logic [PROD_W-1:0]       prod;
  logic                    neg_reg;

  logic signed [WIDE_W-1:0] d;
  logic signed [WIDE_W-1:0] d3;
  logic [TIME_W-1:0]        sub;
  logic [TIME_W-1:0]        rest;
  logic [TIME_W-1:0]        h;
  logic signed [VAL_W:0]    diff;
  logic [VAL_W:0]           diff_abs;
  logic [VAL_W-1:0]         mag;
  logic [MUL_A_W-1:0]       mul_a;
  logic [TIME_W-1:0]        mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [PROD_W-1:0]        rounded;
  logic [INC_W-1:0]         inc;
  logic signed [WIDE_W-1:0] sinc;
  logic signed [WIDE_W-1:0] cur;
  logic signed [VAL_W-1:0]  upd_val;

  assign d  = $signed(WIDE_W'(target_delta));
  assign d3 = (d <<< 1) + d;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_mode    <= MODE_KEYBOARD;
      keyboard_mode <= 1'b0;
      for (int i = 0; i < CHAN_COUNT; i++) begin
        gain[i] <= GAIN_RESET;
      end
      target_delta  <= DELTA_RESET;
      substep_time  <= SUBSTEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INPUT_MODE:    input_mode     <= cfg_data[MODE_W-1:0];
        REG_KEYBOARD_MODE: keyboard_mode  <= cfg_data[0];
        REG_STEERING_GAIN: gain[CH_STR]   <= cfg_data[GAIN_W-1:0];
        REG_THROTTLE_GAIN: gain[CH_THR]   <= cfg_data[GAIN_W-1:0];
        REG_BRAKING_GAIN:  gain[CH_BRK]   <= cfg_data[GAIN_W-1:0];
        REG_CLUTCH_GAIN:   gain[CH_CLU]   <= cfg_data[GAIN_W-1:0];
        REG_TARGET_DELTA:  target_delta   <= cfg_data[DELTA_W-1:0];
        REG_SUBSTEP_TIME:  substep_time   <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode a request: key flags and target nudges
  always_comb begin
    logic signed [VAL_W-1:0] thr_new;
    logic lft;
    logic rgt;
    held_next = held;
    for (int i = 0; i < CHAN_COUNT; i++) begin
      tgt_next[i] = tgt[i];
    end
    thr_new = '0;
    lft = held[KEY_LEFT];
    rgt = held[KEY_RIGHT];
    unique case (op_t'(cmd_item.operation))
      OP_KEY: begin
        for (int i = 0; i < KEY_COUNT; i++) begin
          if (cmd_item.key_id == KEY_ID_W'(i)) held_next[i] = cmd_item.pressed;
        end
      end
      OP_RELEASE_KEYS: held_next = '0;
      OP_THR_UP: begin
        thr_new = clamp_val(WIDE_W'(tgt[CH_THR]) + d, 1'b0);
        tgt_next[CH_THR] = thr_new;
        if (thr_new > 0) tgt_next[CH_BRK] = clamp_val(WIDE_W'(tgt[CH_BRK]) - d3, 1'b0);
      end
      OP_THR_DOWN: begin
        thr_new = clamp_val(WIDE_W'(tgt[CH_THR]) - d3, 1'b0);
        tgt_next[CH_THR] = thr_new;
        if (thr_new <= 0) tgt_next[CH_BRK] = clamp_val(WIDE_W'(tgt[CH_BRK]) + d, 1'b0);
      end
      OP_LEFT:     tgt_next[CH_STR] = clamp_val(WIDE_W'(tgt[CH_STR]) + d, 1'b1);
      OP_RIGHT:    tgt_next[CH_STR] = clamp_val(WIDE_W'(tgt[CH_STR]) - d, 1'b1);
      OP_CLU_UP:   tgt_next[CH_CLU] = clamp_val(WIDE_W'(tgt[CH_CLU]) + d, 1'b0);
      OP_CLU_DOWN: tgt_next[CH_CLU] = clamp_val(WIDE_W'(tgt[CH_CLU]) - d, 1'b0);
      OP_CENTER: begin
        held_next[KEY_LEFT]  = 1'b0;
        held_next[KEY_RIGHT] = 1'b0;
        tgt_next[CH_STR]     = '0;
      end
      OP_RELEASE_PEDALS: begin
        held_next[KEY_THR] = 1'b0;
        held_next[KEY_BRK] = 1'b0;
        held_next[KEY_CLU] = 1'b0;
        tgt_next[CH_THR]   = '0;
        tgt_next[CH_BRK]   = '0;
        tgt_next[CH_CLU]   = '0;
      end
      OP_TICK: begin
        // held mode: keys define the targets, brake wins over throttle
        if (input_mode == MODE_KEYBOARD && keyboard_mode) begin
          tgt_next[CH_THR] = (held[KEY_THR] && !held[KEY_BRK]) ? ONE_V : '0;
          tgt_next[CH_BRK] = held[KEY_BRK] ? ONE_V : '0;
          tgt_next[CH_CLU] = held[KEY_CLU] ? ONE_V : '0;
          tgt_next[CH_STR] = (lft && !rgt) ? ONE_V : ((rgt && !lft) ? -ONE_V : '0);
        end
      end
      OP_CLEAR: begin
        held_next = '0;
        for (int i = 0; i < CHAN_COUNT; i++) begin
          tgt_next[i] = '0;
        end
      end
      default: ;
    endcase
  end

  // Substep length
  assign sub  = (substep_time == '0) ? TIME_W'(1) : substep_time;
  assign rest = step_reg - elapsed;
  assign h    = (sub < rest) ? sub : rest;

  // Shared multiplier: error magnitude times gain, then times substep
  assign diff     = (VAL_W+1)'(tgt[ctl.ch]) - (VAL_W+1)'(smooth[ctl.ch]);
  assign diff_abs = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
  assign mag      = diff_abs[VAL_W-1:0];
  assign mul_a    = ctl.mul_h ? prod[MUL_A_W-1:0] : MUL_A_W'(mag);
  assign mul_b    = ctl.mul_h ? h_reg : gain[ctl.ch];
  assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Round to nearest, ties away from zero, then apply with sign and clamp
  assign rounded = prod + (PROD_W'(1) << (SHIFT - 1));
  assign inc     = rounded[PROD_W-1:SHIFT];
  assign sinc    = $signed(WIDE_W'(inc));
  assign cur     = WIDE_W'(smooth[ctl.ch]);
  assign upd_val = clamp_val(neg_reg ? cur - sinc : cur + sinc, ctl.ch == CH_STR);

  // Control state of the block
  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      elapsed <= '0;
      for (int i = 0; i < CHAN_COUNT; i++) begin
        tgt[i]    <= '0;
        smooth[i] <= '0;
      end
    end else begin
      if (ctl.accept) begin
        held    <= held_next;
        elapsed <= '0;
        for (int i = 0; i < CHAN_COUNT; i++) begin
          tgt[i] <= tgt_next[i];
        end
      end
      if (ctl.start_sub) elapsed <= elapsed + h;
      if (ctl.update) smooth[ctl.ch] <= upd_val;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) step_reg <= cmd_item.step_time;
    if (ctl.start_sub) h_reg <= h;
    if (ctl.mul_mag) neg_reg <= diff[VAL_W];
    if (ctl.mul_mag || ctl.mul_h) prod <= mul_p;
    if (ctl.load_out) begin
      res_item.throttle_out <= smooth[CH_THR][OUT_U_W-1:0];
      res_item.steering_out <= smooth[CH_STR];
      res_item.braking_out  <= smooth[CH_BRK][OUT_U_W-1:0];
      res_item.clutch_out   <= smooth[CH_CLU][OUT_U_W-1:0];
    end
  end

  assign stat.tick_work = (cmd_item.operation == OP_TICK) && (input_mode == MODE_KEYBOARD)
                          && (cmd_item.step_time != '0);
  assign stat.sub_done  = (elapsed == step_reg);

  `KDPS_ASSERT_IMPLY(a_smooth_range, clk, rst, 1'b1, (smooth[CH_STR] >= -ONE_V) && (smooth[CH_STR] <= ONE_V) && (smooth[CH_THR] >= 0) && (smooth[CH_THR] <= ONE_V), "smoothed value left its range")
  `KDPS_ASSERT_NEXT(a_sub_advances, clk, rst, ctl.start_sub, (elapsed > $past(elapsed)) && (elapsed <= step_reg), "substep did not advance time within the tick")

endmodule

@@ rtl/kdps_ctrl.sv @@
// Controller: request handshake, substep and channel sequencing
`include "key_driven_pedal_steer_smoother_top_macros.svh"

module kdps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  output logic                res_valid,
  input  logic                res_stall,
  input  kdps_pkg::ctl_stat_t stat,
  output kdps_pkg::ctl_cmd_t  ctl
);
  import kdps_pkg::*;

  state_t          state;
  state_t          state_next;
  logic [CH_W-1:0] ch;
  logic [CH_W-1:0] ch_next;
  logic            out_free;
  logic            accept;

  // Take a request when idle and the result register is empty or draining
  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = !((state == ST_IDLE) && out_free);
  assign accept    = cmd_valid && !cmd_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept && stat.tick_work) state_next = ST_SUB;
      ST_SUB:     state_next = ST_MUL_MAG;
      ST_MUL_MAG: state_next = ST_MUL_H;
      ST_MUL_H:   state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (ch != CH_LAST) state_next = ST_MUL_MAG;
        else if (stat.sub_done) state_next = ST_FINISH;
        else state_next = ST_SUB;
      end
      ST_FINISH:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Channel counter: restart each substep, advance after each update
  always_comb begin
    ch_next = ch;
    if (state == ST_SUB) ch_next = '0;
    else if (state == ST_UPDATE) ch_next = CH_W'(ch + 1'b1);
  end

  // Commands to the datapath
  always_comb begin
    ctl.accept    = accept;
    ctl.load_out  = (accept && !stat.tick_work) || (state == ST_FINISH);
    ctl.start_sub = (state == ST_SUB);
    ctl.mul_mag   = (state == ST_MUL_MAG);
    ctl.mul_h     = (state == ST_MUL_H);
    ctl.update    = (state == ST_UPDATE);
    ctl.ch        = ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ch        <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      if (ctl.load_out) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  `KDPS_ASSERT_NEXT(a_tick_starts, clk, rst, accept && stat.tick_work, state == ST_SUB, "tick with work did not start a substep")
  `KDPS_ASSERT_IMPLY(a_finish_empty, clk, rst, state == ST_FINISH, !res_valid, "result register occupied at end of tick")
  `KDPS_ASSERT_IMPLY(a_busy_stalls, clk, rst, state != ST_IDLE, cmd_stall && !ctl.accept, "request taken while a tick is running")

endmodule

@@ rtl/key_driven_pedal_steer_smoother_top.sv @@
// Top level of the key-driven pedal and steering smoother
//
//   channel  signals                          carries
//   cmd      cmd_valid, cmd_stall, cmd_item   key commands and ticks in
//   res      res_valid, res_stall, res_item   smoothed controls out
//   cfg      cfg_write, cfg_index, cfg_data   register writes, no wait
//
// Any request other than a working tick gives its result in the cycle after acceptance.
// A keyboard tick with nonzero step_time runs substeps: SUB, then MUL_MAG, MUL_H and
// UPDATE per channel, then FINISH; one 32x16 multiplier is shared across the channels.
// Reset is synchronous and needs no clearing pass; the block is ready the cycle after.
// cmd_stall is high while a tick runs, and while a result waits and res_stall is high.
module key_driven_pedal_steer_smoother_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  kdps_pkg::cmd_item_t             cmd_item,
  output logic                            res_valid,
  input  logic                            res_stall,
  output kdps_pkg::res_item_t             res_item,
  input  logic                            cfg_write,
  input  logic [kdps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdps_pkg::CFG_W-1:0]      cfg_data
);
  import kdps_pkg::*;

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  // Sequencer
  kdps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Registers and arithmetic
  kdps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_item  (cmd_item),
    .ctl       (ctl),
    .stat      (stat),
    .res_item  (res_item)
  );

endmodule

@@ bench/smoother_checker.sv @@
// Checker for the pedal and steering smoother: predicts each result and compares it
module smoother_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  logic                            cmd_stall,
  input  kdps_pkg::cmd_item_t             cmd_item,
  input  logic                            res_valid,
  input  logic                            res_stall,
  input  kdps_pkg::res_item_t             res_item,
  input  logic                            cfg_write,
  input  logic [kdps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdps_pkg::CFG_W-1:0]      cfg_data,
  output int                              errors,
  output int                              pending
);
  import kdps_pkg::*;

  localparam longint ONE       = longint'(1) << VALUE_FRAC_BITS;
  localparam int     LAG_SHIFT = GAIN_FRAC_BITS + TIME_FRAC_BITS;

  // Register copies, gains kept in channel order
  logic [MODE_W-1:0]  mode_reg;
  logic               held_mode;
  logic [GAIN_W-1:0]  gain [CHAN_COUNT];
  logic [DELTA_W-1:0] delta_reg;
  logic [TIME_W-1:0]  substep_reg;

  // Control state
  logic [KEY_COUNT-1:0] keys_down;
  longint               target [CHAN_COUNT];
  longint               smooth [CHAN_COUNT];

  res_item_t expected_controls[$];

  // Clamp to 0..1, or -1..1 for steering
  function automatic longint clamp_to_range(int ch, longint v);
    longint lo;
    lo = (ch == CH_STR) ? -ONE : 0;
    if (v < lo) return lo;
    if (v > ONE) return ONE;
    return v;
  endfunction

  function automatic void nudge(int ch, longint d);
    target[ch] = clamp_to_range(ch, target[ch] + d);
  endfunction

  // One Euler substep of the first-order lag on all four channels
  function automatic void lag_substep(int unsigned h);
    longint diff;
    longint mag;
    longint inc;
    for (int ch = 0; ch < CHAN_COUNT; ch++) begin
      diff = target[ch] - smooth[ch];
      mag  = (diff < 0) ? -diff : diff;
      inc  = (mag * longint'(gain[ch]) * longint'(h) + (longint'(1) << (LAG_SHIFT - 1)))
             >>> LAG_SHIFT;
      smooth[ch] = clamp_to_range(ch, smooth[ch] + ((diff < 0) ? -inc : inc));
    end
  endfunction

  // Integrate one tick; nothing moves outside keyboard input
  function automatic void run_tick(logic [TIME_W-1:0] span);
    int unsigned sub;
    int unsigned done;
    int unsigned h;
    if (mode_reg != MODE_KEYBOARD) return;
    sub = (substep_reg == 0) ? 1 : substep_reg;
    if (held_mode) begin
      target[CH_THR] = (keys_down[KEY_THR] && !keys_down[KEY_BRK]) ? ONE : 0;
      target[CH_BRK] = keys_down[KEY_BRK] ? ONE : 0;
      target[CH_STR] = (keys_down[KEY_LEFT] ? ONE : 0) - (keys_down[KEY_RIGHT] ? ONE : 0);
      target[CH_CLU] = keys_down[KEY_CLU] ? ONE : 0;
    end
    done = 0;
    while (done < span) begin
      h = (span - done < sub) ? span - done : sub;
      lag_substep(h);
      done += h;
    end
  endfunction

  // Apply one request and return the smoothed controls after it
  function automatic res_item_t apply_command(cmd_item_t c);
    longint    d;
    res_item_t r;
    d = longint'(delta_reg);
    case (c.operation)
      OP_KEY: if (c.key_id <= KEY_CLU) keys_down[c.key_id] = c.pressed;
      OP_RELEASE_KEYS: keys_down = '0;
      OP_THR_UP: begin
        nudge(CH_THR, d);
        if (target[CH_THR] > 0) nudge(CH_BRK, -3 * d);
      end
      OP_THR_DOWN: begin
        nudge(CH_THR, -3 * d);
        if (target[CH_THR] <= 0) nudge(CH_BRK, d);
      end
      OP_LEFT:     nudge(CH_STR, d);
      OP_RIGHT:    nudge(CH_STR, -d);
      OP_CLU_UP:   nudge(CH_CLU, d);
      OP_CLU_DOWN: nudge(CH_CLU, -d);
      OP_CENTER: begin
        keys_down[KEY_LEFT]  = 1'b0;
        keys_down[KEY_RIGHT] = 1'b0;
        target[CH_STR] = 0;
      end
      OP_RELEASE_PEDALS: begin
        keys_down[KEY_THR] = 1'b0;
        keys_down[KEY_BRK] = 1'b0;
        keys_down[KEY_CLU] = 1'b0;
        target[CH_THR] = 0;
        target[CH_BRK] = 0;
        target[CH_CLU] = 0;
      end
      OP_TICK: run_tick(c.step_time);
      OP_CLEAR: begin
        keys_down = '0;
        foreach (target[i]) target[i] = 0;
      end
      default: ;
    endcase
    r.throttle_out = smooth[CH_THR][OUT_U_W-1:0];
    r.steering_out = smooth[CH_STR][VAL_W-1:0];
    r.braking_out  = smooth[CH_BRK][OUT_U_W-1:0];
    r.clutch_out   = smooth[CH_CLU][OUT_U_W-1:0];
    return r;
  endfunction

  // Track register writes, predict accepted requests, compare delivered results
  always @(posedge clk) begin
    res_item_t want;
    bit        bad;
    if (rst) begin
      mode_reg    = MODE_KEYBOARD;
      held_mode   = 1'b0;
      foreach (gain[i]) gain[i] = GAIN_RESET;
      delta_reg   = DELTA_RESET;
      substep_reg = SUBSTEP_RESET;
      keys_down   = '0;
      foreach (target[i]) target[i] = 0;
      foreach (smooth[i]) smooth[i] = 0;
      expected_controls.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_INPUT_MODE:    mode_reg       = cfg_data[MODE_W-1:0];
          REG_KEYBOARD_MODE: held_mode      = cfg_data[0];
          REG_STEERING_GAIN: gain[CH_STR]   = cfg_data[GAIN_W-1:0];
          REG_THROTTLE_GAIN: gain[CH_THR]   = cfg_data[GAIN_W-1:0];
          REG_BRAKING_GAIN:  gain[CH_BRK]   = cfg_data[GAIN_W-1:0];
          REG_CLUTCH_GAIN:   gain[CH_CLU]   = cfg_data[GAIN_W-1:0];
          REG_TARGET_DELTA:  delta_reg      = cfg_data[DELTA_W-1:0];
          REG_SUBSTEP_TIME:  substep_reg    = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      // Compare before queueing, so a stray result never meets this cycle's request
      if (res_valid && !res_stall) begin
        if (expected_controls.size() == 0) begin
          $error("result delivered with no request outstanding");
          errors++;
        end else begin
          want = expected_controls.pop_front();
          bad  = 1'b0;
          if (res_item.throttle_out !== want.throttle_out) begin
            $error("throttle_out: expected %0d, got %0d", want.throttle_out,
                   res_item.throttle_out);
            bad = 1'b1;
          end
          if (res_item.steering_out !== want.steering_out) begin
            $error("steering_out: expected %0d, got %0d", want.steering_out,
                   res_item.steering_out);
            bad = 1'b1;
          end
          if (res_item.braking_out !== want.braking_out) begin
            $error("braking_out: expected %0d, got %0d", want.braking_out,
                   res_item.braking_out);
            bad = 1'b1;
          end
          if (res_item.clutch_out !== want.clutch_out) begin
            $error("clutch_out: expected %0d, got %0d", want.clutch_out,
                   res_item.clutch_out);
            bad = 1'b1;
          end
          if (bad) errors++;
        end
      end
      if (cmd_valid && !cmd_stall) expected_controls.push_back(apply_command(cmd_item));
    end
    pending <= expected_controls.size();
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the pedal and steering smoother: stimulus, back-pressure and verdict
module tb;
  import kdps_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 300;

  // Register values without a name in the package
  localparam logic [CFG_W-1:0] MODE_JOYSTICK = 16'd1;
  localparam logic [CFG_W-1:0] MODE_LOCKED   = 16'd2;
  localparam logic [CFG_W-1:0] CUMULATIVE    = 16'd0;
  localparam logic [CFG_W-1:0] HELD_KEYS     = 16'd1;

  // Request codes the block ignores
  localparam logic [OP_W-1:0]     OP_UNUSED_LO  = 4'd12;
  localparam logic [OP_W-1:0]     OP_UNUSED_HI  = 4'd15;
  localparam int                  KEY_UNUSED_HI = 7;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  cmd_item_t            cmd_item  = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_item_t            res_item;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int          errors;
  int          pending;
  int          cycles   = 0;
  int          sent     = 0;
  int          settings = 0;
  logic [TIME_W-1:0] live_substep = SUBSTEP_RESET;
  logic [MODE_W-1:0] live_mode    = MODE_KEYBOARD;
  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;

  always #2 clk = ~clk;

  key_driven_pedal_steer_smoother_top dut (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd_item, .res_valid, .res_stall, .res_item,
    .cfg_write, .cfg_index, .cfg_data
  );

  smoother_checker watcher (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd_item, .res_valid, .res_stall, .res_item,
    .cfg_write, .cfg_index, .cfg_data, .errors, .pending
  );

  // Give up after a generous number of cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: short random stalls, one long hold-off on demand
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        res_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  function automatic cmd_item_t mk(logic [OP_W-1:0] op, int key, bit pr, int span);
    cmd_item_t it;
    it.operation = op;
    it.key_id    = key[KEY_ID_W-1:0];
    it.pressed   = pr;
    it.step_time = span[TIME_W-1:0];
    return it;
  endfunction

  // Random request; tick length kept to a few substeps where ticks integrate
  function automatic cmd_item_t rand_cmd();
    cmd_item_t   it;
    int unsigned pick;
    int unsigned cap;
    op_t         rare [4] = '{OP_RELEASE_KEYS, OP_CENTER, OP_RELEASE_PEDALS, OP_CLEAR};
    it.key_id  = KEY_ID_W'(($urandom_range(0, 9) == 0)
                           ? $urandom_range(KEY_CLU + 1, KEY_UNUSED_HI)
                           : $urandom_range(0, KEY_CLU));
    it.pressed = 1'($urandom_range(0, 1));
    cap = (live_substep == 0) ? 6 : 6 * int'(live_substep);
    if (cap > 65535 || live_mode != MODE_KEYBOARD) cap = 65535;
    it.step_time = TIME_W'($urandom_range(0, cap));
    pick = $urandom_range(0, 99);
    if (pick < 30)      it.operation = OP_KEY;
    else if (pick < 60) it.operation = OP_TICK;
    else if (pick < 85) it.operation = OP_W'($urandom_range(OP_THR_UP, OP_CLU_DOWN));
    else if (pick < 95) it.operation = rare[$urandom_range(0, 3)];
    else                it.operation = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    return it;
  endfunction

  // Offer one request, with a random gap first, and hold it until accepted
  task automatic send(input cmd_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd_item  <= it;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    sent++;
  endtask

  task automatic run_random(input int n);
    repeat (n) send(rand_cmd());
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  // Reprogramme every register once the block is idle
  task automatic setup(input logic [CFG_W-1:0] mode, kb, steer, thr, brk, clu, dlt, sub);
    drain();
    write_reg(REG_INPUT_MODE, mode);
    write_reg(REG_KEYBOARD_MODE, kb);
    write_reg(REG_STEERING_GAIN, steer);
    write_reg(REG_THROTTLE_GAIN, thr);
    write_reg(REG_BRAKING_GAIN, brk);
    write_reg(REG_CLUTCH_GAIN, clu);
    write_reg(REG_TARGET_DELTA, dlt);
    write_reg(REG_SUBSTEP_TIME, sub);
    cfg_write <= 1'b0;
    live_mode    = mode[MODE_W-1:0];
    live_substep = sub;
    settings++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under reset settings
    send(mk(OP_KEY, KEY_THR, 1'b1, 0));
    send(mk(OP_KEY, KEY_BRK, 1'b1, 65535));
    send(mk(OP_KEY, KEY_LEFT, 1'b1, 0));
    send(mk(OP_KEY, KEY_RIGHT, 1'b1, 0));
    send(mk(OP_KEY, KEY_CLU, 1'b1, 0));
    send(mk(OP_KEY, KEY_UNUSED_HI, 1'b1, 0));
    send(mk(OP_THR_UP, 0, 1'b0, 0));
    send(mk(OP_THR_UP, 0, 1'b0, 0));
    send(mk(OP_THR_DOWN, 0, 1'b0, 0));
    send(mk(OP_THR_DOWN, 0, 1'b0, 0));
    send(mk(OP_LEFT, 0, 1'b0, 0));
    send(mk(OP_RIGHT, 0, 1'b0, 0));
    send(mk(OP_RIGHT, 0, 1'b0, 0));
    send(mk(OP_CLU_UP, 0, 1'b0, 0));
    send(mk(OP_CLU_DOWN, 0, 1'b0, 0));
    send(mk(OP_CLU_DOWN, 0, 1'b0, 0));
    send(mk(OP_TICK, 0, 1'b0, 0));
    send(mk(OP_TICK, 0, 1'b0, 200));
    send(mk(OP_CENTER, 0, 1'b0, 0));
    send(mk(OP_RELEASE_PEDALS, 0, 1'b0, 0));
    send(mk(OP_RELEASE_KEYS, 0, 1'b0, 0));
    send(mk(OP_CLEAR, 0, 1'b0, 0));
    send(mk(OP_UNUSED_LO, 0, 1'b0, 0));
    send(mk(OP_UNUSED_HI, KEY_UNUSED_HI, 1'b1, 65535));
    send(mk(OP_TICK, 0, 1'b0, 66));

    // Cumulative nudging; long result hold-off, then a full pause on the request side
    setup(CFG_W'(MODE_KEYBOARD), CUMULATIVE, 1024, 1024, 1024, 1024, 328, 66);
    run_random(40);
    hold_req = 1'b1;
    run_random(40);
    drain();
    run_random(50);

    // Largest gains and substep, delta of one full unit: one substep per tick, full tick range
    setup(CFG_W'(MODE_KEYBOARD), HELD_KEYS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16384,
          16'hFFFF);
    run_random(100);

    // Zero gains and delta, smallest substep
    setup(CFG_W'(MODE_KEYBOARD), HELD_KEYS, 0, 0, 0, 0, 0, 1);
    run_random(60);

    // Joystick input: ticks leave the values alone
    setup(MODE_JOYSTICK, HELD_KEYS, CFG_W'($urandom_range(0, 65535)),
          CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
          CFG_W'($urandom_range(0, 65535)), 1000, 100);
    run_random(60);

    // Uneven gains, delta with all bits set, substep of zero
    setup(CFG_W'(MODE_KEYBOARD), CUMULATIVE, 300, 5000, 40000, 777, 16'hFFFF, 0);
    run_random(80);

    // Spare mode code, with upper data bits that the registers drop
    setup(16'hFFFF, 16'hFFFE, 16'h8001, 16'h0100, 16'h2000, 16'h0400, 16'hC148, 16'h8042);
    run_random(50);

    // Locked input
    setup(MODE_LOCKED, HELD_KEYS, 2048, 512, 256, 4096, 500, 33);
    run_random(40);

    // Held keys with random settings
    setup(CFG_W'(MODE_KEYBOARD), HELD_KEYS, CFG_W'($urandom_range(0, 65535)),
          CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
          CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 16384)),
          CFG_W'($urandom_range(1, 65535)));
    run_random(150);

    // Closing stretch with no idling on either side
    calm = 1'b1;
    setup(CFG_W'(MODE_KEYBOARD), CUMULATIVE, 1024, 1024, 1024, 1024, 328, 66);
    run_random(150);

    drain();
    repeat (150) @(posedge clk);
    $display("Run covered %0d requests over %0d register settings: cumulative and held keys,",
             sent, settings);
    $display("joystick, locked and spare modes, zero and full gains, and a long result hold-off.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
